>>> rtl/core/ptsm_pkg.sv
package ptsm_pkg;

    // Default field widths for the channel interfaces
    localparam int DEF_VALUE_WIDTH   = 31;
    localparam int DEF_FRACTION_BITS = 16;

    // Fixed-point arithmetic wraps at this many bits
    localparam int ARITH_CAP = 64;

endpackage

>>> rtl/core/ptsm_if.sv
interface ptsm_in_if #(
    parameter int VALUE_WIDTH = ptsm_pkg::DEF_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value_in;
    logic                   last_in;

    modport source (output valid, output value_in, output last_in, input ready);
    modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface ptsm_out_if #(
    parameter int VALUE_WIDTH   = ptsm_pkg::DEF_VALUE_WIDTH,
    parameter int FRACTION_BITS = ptsm_pkg::DEF_FRACTION_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [VALUE_WIDTH+FRACTION_BITS-1:0] output_value;
    logic                                 is_prime;
    logic                                 last_out;

    modport source (output valid, output output_value, output is_prime, output last_out,
                    input ready);
    modport sink   (input valid, input output_value, input is_prime, input last_out,
                    output ready);
endinterface

>>> rtl/core/prime_test_sqrt_map.sv
// Flow: 0, 1 and even values above 2 go straight to the finish state; any other value
//   passes a bound check and a bit-serial remainder pass for each odd trial divisor
//   (3, 5, 7 and so on while d*d <= value), then takes one step per root bit if prime.
// Throughput: one word at a time, taken only in the idle state; the worst case is set
//   by the bit-serial remainder steps of the shared subtract unit.
// Reset (i_rst_n, synchronous, active low) empties the output register and idles.
module prime_test_sqrt_map #(
    parameter int VALUE_WIDTH   = 31,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptsm_in_if.sink     i_in,
    ptsm_out_if.source  o_out
);

    localparam int OW  = VALUE_WIDTH + FRACTION_BITS;
    localparam int XW  = VALUE_WIDTH + 2 * FRACTION_BITS;
    localparam int RW  = (XW < ptsm_pkg::ARITH_CAP) ? XW : ptsm_pkg::ARITH_CAP;
    localparam int SRW = RW + (RW % 2);
    localparam int RH  = SRW / 2;
    localparam int DW  = (VALUE_WIDTH + 1) / 2 + 2;
    localparam int QW  = VALUE_WIDTH + 1;
    localparam int RMW = (DW > RH + 1) ? DW : RH + 1;
    localparam int SW  = (DW + 1 > RH + 3) ? DW + 1 : RH + 3;
    localparam int CNT_MAX = (VALUE_WIDTH > RH) ? VALUE_WIDTH : RH;
    localparam int CW  = $clog2(CNT_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_DIV,
        S_SQRT,
        S_FIN
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_ovalid, n_ovalid;
    logic [VALUE_WIDTH-1:0] r_v, n_v;
    logic                   r_last, n_last;
    logic                   r_prime, n_prime;
    logic [DW-1:0]          r_d, n_d;
    logic [QW-1:0]          r_dsq, n_dsq;
    logic [RMW-1:0]         r_rem, n_rem;
    logic [RH-1:0]          r_root, n_root;
    logic [SRW-1:0]         r_sh, n_sh;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [OW-1:0]          r_oval, n_oval;
    logic                   r_oprime, n_oprime;
    logic                   r_olast, n_olast;

    // Shared subtract/compare unit
    logic [SW-1:0] a_op, b_op;
    logic [SW:0]   diff;
    logic          ge;

    logic [XW-1:0] rad_full;
    logic [OW-1:0] scaled;
    logic [OW-1:0] cap_mask;
    logic          out_free;

    // Pick operands: remainder step while dividing, root step otherwise
    always_comb begin
        if (r_state == S_DIV) begin
            a_op = SW'({r_rem[DW-1:0], r_sh[SRW-1]});
            b_op = SW'(r_d);
        end else begin
            a_op = SW'({r_rem[RH:0], r_sh[SRW-1 -: 2]});
            b_op = SW'({r_root, 2'b01});
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = !diff[SW];
    end

    // Radicand and pass-through scaling, wrapped at the arithmetic cap
    always_comb begin
        rad_full = XW'(r_v) << (2 * FRACTION_BITS);
        scaled   = OW'(r_v) << FRACTION_BITS;
        for (int i = 0; i < OW; i++) begin
            cap_mask[i] = (i < ptsm_pkg::ARITH_CAP);
        end
    end

    assign out_free = !r_ovalid || o_out.ready;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_v      = r_v;
        n_last   = r_last;
        n_prime  = r_prime;
        n_d      = r_d;
        n_dsq    = r_dsq;
        n_rem    = r_rem;
        n_root   = r_root;
        n_sh     = r_sh;
        n_cnt    = r_cnt;
        n_oval   = r_oval;
        n_oprime = r_oprime;
        n_olast  = r_olast;

        // drop the word once taken
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_v     = i_in.value_in;
                    n_last  = i_in.last_in;
                    n_prime = 1'b0;
                    n_d     = DW'(3);
                    n_dsq   = QW'(9);
                    if (i_in.value_in < VALUE_WIDTH'(2) ||
                        (!i_in.value_in[0] && i_in.value_in != VALUE_WIDTH'(2))) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_BOUND;
                    end
                end
            end
            S_BOUND: begin
                n_rem = '0;
                if (r_dsq > {1'b0, r_v}) begin
                    // no divisor left: prime, start the root
                    n_prime = 1'b1;
                    n_root  = '0;
                    n_sh    = SRW'(rad_full[RW-1:0]);
                    n_cnt   = CW'(RH - 1);
                    n_state = S_SQRT;
                end else begin
                    n_sh    = SRW'(r_v) << (SRW - VALUE_WIDTH);
                    n_cnt   = CW'(VALUE_WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one remainder bit per cycle
                n_rem = ge ? RMW'(diff[DW-1:0]) : RMW'(a_op[DW-1:0]);
                n_sh  = r_sh << 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    if (n_rem == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_d     = r_d + DW'(2);
                        n_dsq   = r_dsq + QW'({r_d, 2'b00}) + QW'(4);
                        n_state = S_BOUND;
                    end
                end
            end
            S_SQRT: begin
                // one root bit per cycle
                n_rem  = ge ? RMW'(diff[RH:0]) : RMW'(a_op[RH:0]);
                n_root = {r_root[RH-2:0], ge};
                n_sh   = r_sh << 2;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_oval   = r_prime ? OW'(r_root) : (scaled & cap_mask);
                    n_oprime = r_prime;
                    n_olast  = r_last;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_v      <= n_v;
        r_last   <= n_last;
        r_prime  <= n_prime;
        r_d      <= n_d;
        r_dsq    <= n_dsq;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_sh     <= n_sh;
        r_cnt    <= n_cnt;
        r_oval   <= n_oval;
        r_oprime <= n_oprime;
        r_olast  <= n_olast;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.output_value = r_oval;
    assign o_out.is_prime     = r_oprime;
    assign o_out.last_out     = r_olast;

    // Zero and one go straight to the result as composite
    a_small_composite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.value_in < VALUE_WIDTH'(2))
        |=> (r_state == S_FIN && !r_prime))
        else $error("small value not flagged composite");

    // Partial remainder stays below the trial divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem[DW-1:0] < r_d))
        else $error("remainder out of range");

    // A divisor is only tried while its square fits the value
    a_div_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dsq <= {1'b0, r_v}))
        else $error("divisor beyond square root");

    // A new result word appears only out of the finish state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result word without finish");

endmodule
